// File: src/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication, antecedent and consequent given apart
`define CHK_NEXT(lbl, ante, cons, msg) \
  `CHK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: src/bwtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwtp_pkg
// Shared types and codes of the binary wire token parser.
// ----------------------------------------------------------------------------
package bwtp_pkg;

  localparam int NestDepth = 10;
  localparam int PosWidth  = 32;
  localparam int KindW     = 5;
  localparam int DepthW    = 4;
  localparam int PopsW     = 4;
  localparam int ModeW     = 3;
  localparam int TargetW   = 5;
  localparam int ShiftW    = 7;

  // parse modes
  localparam logic [ModeW-1:0] ModeCtrl  = 3'd0;
  localparam logic [ModeW-1:0] ModeLen   = 3'd1;
  localparam logic [ModeW-1:0] ModeName  = 3'd2;
  localparam logic [ModeW-1:0] ModeLe    = 3'd3;
  localparam logic [ModeW-1:0] ModeSkip  = 3'd4;
  localparam logic [ModeW-1:0] ModeElem  = 3'd5;
  localparam logic [ModeW-1:0] ModeAbort = 3'd6;

  // result kinds
  localparam logic [KindW-1:0] KUint8      = 5'd0;
  localparam logic [KindW-1:0] KUint16     = 5'd1;
  localparam logic [KindW-1:0] KUint32     = 5'd2;
  localparam logic [KindW-1:0] KUint64     = 5'd3;
  localparam logic [KindW-1:0] KEventStart = 5'd4;
  localparam logic [KindW-1:0] KTypeStart  = 5'd6;
  localparam logic [KindW-1:0] KFieldStart = 5'd8;
  localparam logic [KindW-1:0] KTextStart  = 5'd10;
  localparam logic [KindW-1:0] KArrayHead  = 5'd12;
  localparam logic [KindW-1:0] KElement    = 5'd13;
  localparam logic [KindW-1:0] KNest       = 5'd14;
  localparam logic [KindW-1:0] KSkip       = 5'd15;
  localparam logic [KindW-1:0] KBadCtrl    = 5'd16;
  localparam logic [KindW-1:0] KOverflow   = 5'd17;

  // collect targets beyond the plain ints
  localparam logic [TargetW-1:0] TPad32 = 5'd20;
  localparam logic [TargetW-1:0] TFloat = 5'd21;
  localparam logic [TargetW-1:0] TNest  = 5'd22;
  localparam logic [TargetW-1:0] TACap  = 5'd23;
  localparam logic [TargetW-1:0] TAUsed = 5'd24;

  // control bytes
  localparam logic [7:0] CtlEvent  = 8'hB9;
  localparam logic [7:0] CtlType   = 8'hB6;
  localparam logic [7:0] CtlText   = 8'hB8;
  localparam logic [7:0] CtlPad    = 8'h8F;
  localparam logic [7:0] CtlPad32  = 8'h8E;
  localparam logic [7:0] CtlFloat  = 8'h90;
  localparam logic [7:0] CtlNest   = 8'h82;
  localparam logic [7:0] CtlArray  = 8'h8D;
  localparam logic [7:0] CtlInt16  = 8'hA5;
  localparam logic [7:0] CtlInt32  = 8'hA6;
  localparam logic [7:0] CtlInt64  = 8'hA7;
  localparam logic [7:0] CtlField  = 8'hC0;
  localparam logic [7:0] CtlShortT = 8'hE0;

  typedef struct packed {
    logic step;
    logic rd;
    logic pop;
    logic load;
    logic clear;
  } bwtp_cmd_t;

  typedef struct packed {
    logic step_chk;
    logic pop_hit;
    logic emit;
    logic last;
    logic out_busy;
  } bwtp_status_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// File: src/binary_wire_token_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_wire_token_parser_unit
// Byte-at-a-time parser for a tagged binary wire buffer.
// ----------------------------------------------------------------------------
// Takes one byte per input word and gives at most one result word per byte.
// A byte that ends no token, or that raises an error, goes straight to
// the finish state; for one that ends a token the sequencer first reads
// and compares the top of the end-position memory, and every nesting level
// it closes adds another read and compare. The next byte is taken while the
// previous result still waits at the output, but a byte with a result of
// its own then holds in its last cycle until that word has left.
// Bytes after an unknown control byte or a nesting overflow give no results
// until the word marked tlast, which returns the parser to its reset state.
module binary_wire_token_parser_unit #(
  parameter int NEST_DEPTH = bwtp_pkg::NestDepth,
  parameter int POS_WIDTH  = bwtp_pkg::PosWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // byte_in
  input  logic         s_axis_tlast_i,   // last_in_buffer
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o,   // value[63:0], aux_value, depth[3:0], pops[3:0]
  output logic [4:0]   m_axis_tuser_o,   // kind
  output logic         m_axis_tlast_o    // token_end
);

  bwtp_pkg::bwtp_cmd_t    cmd;
  bwtp_pkg::bwtp_status_t st;
  logic [63:0]            value, aux;
  logic [3:0]             depth, pops;

  bwtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bwtp_datapath #(
    .NEST_DEPTH (NEST_DEPTH),
    .POS_WIDTH  (POS_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (m_axis_tuser_o),
    .value_o     (value),
    .aux_o       (aux),
    .depth_o     (depth),
    .pops_o      (pops),
    .end_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {pops, depth, aux, value};

endmodule

// File: src/bwtp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwtp_ctrl
// Sequencer: takes a byte, walks closed nesting levels, hands off the result.
// ----------------------------------------------------------------------------
module bwtp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bwtp_pkg::bwtp_status_t st_i,
  output bwtp_pkg::bwtp_cmd_t    cmd_o
);

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SPopRd  = 2'd1;
  localparam logic [1:0] SPopCmp = 2'd2;
  localparam logic [1:0] SFinish = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          state_d    = st_i.step_chk ? SPopRd : SFinish;
        end
      end
      SPopRd: begin
        cmd_o.rd = 1'b1;
        state_d  = SPopCmp;
      end
      SPopCmp: begin
        if (st_i.pop_hit) begin
          cmd_o.pop = 1'b1;
          state_d   = SPopRd;
        end else begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        // wait only if a result must go out and the output word is still held
        if (!(st_i.emit && st_i.out_busy)) begin
          cmd_o.load  = st_i.emit;
          cmd_o.clear = st_i.last;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/bwtp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwtp_datapath
// Token decode, value assembly, nesting end-position memory and output word.
// ----------------------------------------------------------------------------
module bwtp_datapath #(
  parameter int NEST_DEPTH = bwtp_pkg::NestDepth,
  parameter int POS_WIDTH  = bwtp_pkg::PosWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  byte_i,
  input  logic                        last_i,
  input  bwtp_pkg::bwtp_cmd_t          cmd_i,
  output bwtp_pkg::bwtp_status_t       st_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bwtp_pkg::KindW-1:0]  kind_o,
  output logic [63:0]                 value_o,
  output logic [63:0]                 aux_o,
  output logic [bwtp_pkg::DepthW-1:0] depth_o,
  output logic [bwtp_pkg::PopsW-1:0]  pops_o,
  output logic                        end_o
);

  localparam int LW     = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int EntryW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;
  localparam logic [LW-1:0] LevelTop = LW'(NEST_DEPTH - 1);

  // parse state
  logic [POS_WIDTH-1:0]         pos_q, pos_d;
  logic [LW-1:0]                level_q, level_d;
  logic [bwtp_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [31:0]                  left_q, left_d;
  logic [63:0]                  acc_q, acc_d;
  logic [63:0]                  cap_q, cap_d;
  logic [31:0]                  elem_q, elem_d;
  logic [bwtp_pkg::ShiftW-1:0]  shift_q, shift_d;
  logic [bwtp_pkg::TargetW-1:0] subt_q, subt_d;

  // held result of the current byte
  logic                         emit_q, last_q, end_q;
  logic [bwtp_pkg::KindW-1:0]   kind_q;
  logic [63:0]                  val_q, aux_q;
  logic [LW-1:0]                pops_q;

  // nesting end positions
  logic [EntryW-1:0]            nest_mem [NEST_DEPTH];
  logic [EntryW-1:0]            rd_q;

  // output word
  logic                         out_valid_q;
  logic [bwtp_pkg::KindW-1:0]   okind_q;
  logic [63:0]                  oval_q, oaux_q;
  logic [bwtp_pkg::DepthW-1:0]  odepth_q;
  logic [bwtp_pkg::PopsW-1:0]   opops_q;
  logic                         oend_q;

  // step logic
  logic                         s_emit, s_end, push;
  logic [bwtp_pkg::KindW-1:0]   s_kind;
  logic [63:0]                  s_val, s_aux, acc_n;
  logic [POS_WIDTH-1:0]         pos_after;
  logic [EntryW-1:0]            push_end;
  logic [31:0]                  left_n, elem_n;
  logic                         col, col_elem, nm, fl;
  logic [31:0]                  col_n;
  logic [bwtp_pkg::TargetW-1:0] col_t;
  logic [bwtp_pkg::KindW-1:0]   nm_k, fl_k;
  logic [63:0]                  nm_len, fl_v;

  always_comb begin
    pos_d    = pos_q;
    level_d  = level_q;
    mode_d   = mode_q;
    left_d   = left_q;
    acc_d    = acc_q;
    cap_d    = cap_q;
    elem_d   = elem_q;
    shift_d  = shift_q;
    subt_d   = subt_q;
    s_emit   = 1'b0;
    s_end    = 1'b0;
    s_kind   = '0;
    s_val    = '0;
    s_aux    = '0;
    push     = 1'b0;
    acc_n    = acc_q;
    left_n   = left_q - 32'd1;
    elem_n   = elem_q - 32'd1;
    col      = 1'b0;
    col_elem = 1'b0;
    col_n    = '0;
    col_t    = '0;
    nm       = 1'b0;
    nm_k     = '0;
    nm_len   = '0;
    fl       = 1'b0;
    fl_k     = '0;
    fl_v     = '0;
    pos_after = (&pos_q) ? pos_q : pos_q + POS_WIDTH'(1);
    pos_d    = pos_after;
    push_end = EntryW'(pos_after) + EntryW'(acc_n[31:0]);

    case (mode_q)
      bwtp_pkg::ModeCtrl: begin
        if (!byte_i[7]) begin
          s_emit = 1'b1;
          s_kind = bwtp_pkg::KUint8;
          s_val  = 64'(byte_i);
          s_end  = 1'b1;
        end else if (byte_i >= bwtp_pkg::CtlShortT) begin
          nm     = 1'b1;
          nm_k   = bwtp_pkg::KTextStart;
          nm_len = 64'(byte_i[4:0]);
        end else if (byte_i >= bwtp_pkg::CtlField) begin
          nm     = 1'b1;
          nm_k   = bwtp_pkg::KFieldStart;
          nm_len = 64'(byte_i[4:0]);
        end else begin
          case (byte_i)
            bwtp_pkg::CtlEvent, bwtp_pkg::CtlType, bwtp_pkg::CtlText: begin
              mode_d  = bwtp_pkg::ModeLen;
              subt_d  = (byte_i == bwtp_pkg::CtlEvent) ? bwtp_pkg::KEventStart :
                        (byte_i == bwtp_pkg::CtlType)  ? bwtp_pkg::KTypeStart :
                                                          bwtp_pkg::KTextStart;
              acc_d   = '0;
              shift_d = '0;
            end
            bwtp_pkg::CtlPad: begin
              s_emit = 1'b1;
              s_kind = bwtp_pkg::KSkip;
              s_end  = 1'b1;
            end
            bwtp_pkg::CtlPad32: begin col = 1'b1; col_n = 32'd4; col_t = bwtp_pkg::TPad32; end
            bwtp_pkg::CtlFloat: begin col = 1'b1; col_n = 32'd4; col_t = bwtp_pkg::TFloat; end
            bwtp_pkg::CtlNest:  begin col = 1'b1; col_n = 32'd4; col_t = bwtp_pkg::TNest; end
            bwtp_pkg::CtlArray: begin col = 1'b1; col_n = 32'd8; col_t = bwtp_pkg::TACap; end
            bwtp_pkg::CtlInt16: begin col = 1'b1; col_n = 32'd2; col_t = bwtp_pkg::KUint16; end
            bwtp_pkg::CtlInt32: begin col = 1'b1; col_n = 32'd4; col_t = bwtp_pkg::KUint32; end
            bwtp_pkg::CtlInt64: begin col = 1'b1; col_n = 32'd8; col_t = bwtp_pkg::KUint64; end
            default: begin
              fl   = 1'b1;
              fl_k = bwtp_pkg::KBadCtrl;
              fl_v = 64'(byte_i);
            end
          endcase
        end
      end
      bwtp_pkg::ModeLen: begin
        // stop-bit length, seven bits a byte, low group first
        if (shift_q < 7'd64) acc_n = acc_q | (64'(byte_i[6:0]) << shift_q);
        acc_d = acc_n;
        if (shift_q < 7'd70) shift_d = shift_q + 7'd7;
        if (!byte_i[7]) begin
          nm     = 1'b1;
          nm_k   = subt_q;
          nm_len = acc_n;
        end
      end
      bwtp_pkg::ModeName: begin
        left_d = left_n;
        s_emit = 1'b1;
        s_kind = subt_q + bwtp_pkg::KindW'(1);
        s_val  = 64'(byte_i);
        s_end  = (left_n == 32'd0);
        if (left_n == 32'd0) mode_d = bwtp_pkg::ModeCtrl;
      end
      bwtp_pkg::ModeLe, bwtp_pkg::ModeElem: begin
        if (shift_q < 7'd64) acc_n = acc_q | (64'(byte_i) << shift_q);
        acc_d   = acc_n;
        shift_d = shift_q + 7'd8;
        left_d  = left_n;
        push_end = EntryW'(pos_after) + EntryW'(acc_n[31:0]);
        if (left_n == 32'd0) begin
          if (mode_q == bwtp_pkg::ModeLe) begin
            mode_d = bwtp_pkg::ModeCtrl;
            case (subt_q)
              bwtp_pkg::KUint16, bwtp_pkg::KUint32, bwtp_pkg::KUint64: begin
                s_emit = 1'b1;
                s_kind = subt_q;
                s_val  = acc_n;
                s_end  = 1'b1;
              end
              bwtp_pkg::TPad32: begin
                if (acc_n == 64'd0) begin
                  s_emit = 1'b1;
                  s_kind = bwtp_pkg::KSkip;
                  s_end  = 1'b1;
                end else begin
                  mode_d = bwtp_pkg::ModeSkip;
                  left_d = bwtp_pkg::sat32(acc_n);
                end
              end
              bwtp_pkg::TFloat: begin
                s_emit = 1'b1;
                s_kind = bwtp_pkg::KSkip;
                s_end  = 1'b1;
              end
              bwtp_pkg::TNest: begin
                if (level_q >= LevelTop) begin
                  fl   = 1'b1;
                  fl_k = bwtp_pkg::KOverflow;
                  fl_v = acc_n;
                end else begin
                  push    = 1'b1;
                  level_d = level_q + LW'(1);
                  s_emit  = 1'b1;
                  s_kind  = bwtp_pkg::KNest;
                  s_val   = acc_n;
                  s_end   = 1'b1;
                end
              end
              bwtp_pkg::TACap: begin
                cap_d = acc_n;
                col   = 1'b1;
                col_n = 32'd8;
                col_t = bwtp_pkg::TAUsed;
              end
              default: begin
                // used count: header carries capacity alongside
                elem_d = bwtp_pkg::sat32(cap_q);
                s_emit = 1'b1;
                s_kind = bwtp_pkg::KArrayHead;
                s_val  = acc_n;
                s_aux  = cap_q;
                s_end  = (bwtp_pkg::sat32(cap_q) == 32'd0);
                if (bwtp_pkg::sat32(cap_q) != 32'd0) begin
                  col      = 1'b1;
                  col_elem = 1'b1;
                  col_n    = 32'd8;
                  col_t    = '0;
                end
              end
            endcase
          end else begin
            elem_d = elem_n;
            s_emit = 1'b1;
            s_kind = bwtp_pkg::KElement;
            s_val  = acc_n;
            s_end  = (elem_n == 32'd0);
            mode_d = bwtp_pkg::ModeCtrl;
            if (elem_n != 32'd0) begin
              col      = 1'b1;
              col_elem = 1'b1;
              col_n    = 32'd8;
              col_t    = '0;
            end
          end
        end
      end
      bwtp_pkg::ModeSkip: begin
        left_d = left_n;
        if (left_n == 32'd0) begin
          s_emit = 1'b1;
          s_kind = bwtp_pkg::KSkip;
          s_end  = 1'b1;
          mode_d = bwtp_pkg::ModeCtrl;
        end
      end
      default: ;
    endcase

    if (col) begin
      mode_d  = col_elem ? bwtp_pkg::ModeElem : bwtp_pkg::ModeLe;
      left_d  = col_n;
      subt_d  = col_t;
      acc_d   = '0;
      shift_d = '0;
    end
    if (nm) begin
      s_emit = 1'b1;
      s_kind = nm_k;
      s_val  = nm_len;
      s_end  = (nm_len == 64'd0);
      if (nm_len != 64'd0) begin
        mode_d = bwtp_pkg::ModeName;
        subt_d = nm_k;
        left_d = bwtp_pkg::sat32(nm_len);
      end else begin
        mode_d = bwtp_pkg::ModeCtrl;
      end
    end
    if (fl) begin
      s_emit = 1'b1;
      s_kind = fl_k;
      s_val  = fl_v;
      s_end  = 1'b1;
      mode_d = bwtp_pkg::ModeAbort;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      level_q <= '0;
      mode_q  <= bwtp_pkg::ModeCtrl;
      left_q  <= '0;
      acc_q   <= '0;
      cap_q   <= '0;
      elem_q  <= '0;
      shift_q <= '0;
      subt_q  <= '0;
      emit_q  <= 1'b0;
      last_q  <= 1'b0;
      pops_q  <= '0;
    end else if (cmd_i.step) begin
      pos_q   <= pos_d;
      level_q <= level_d;
      mode_q  <= mode_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      cap_q   <= cap_d;
      elem_q  <= elem_d;
      shift_q <= shift_d;
      subt_q  <= subt_d;
      emit_q  <= s_emit;
      last_q  <= last_i;
      pops_q  <= '0;
    end else if (cmd_i.pop) begin
      level_q <= level_q - LW'(1);
      pops_q  <= pops_q + LW'(1);
    end else if (cmd_i.clear) begin
      // buffer ended: back to the reset state
      pos_q   <= '0;
      level_q <= '0;
      mode_q  <= bwtp_pkg::ModeCtrl;
      left_q  <= '0;
      acc_q   <= '0;
      cap_q   <= '0;
      elem_q  <= '0;
      shift_q <= '0;
      subt_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      kind_q <= s_kind;
      val_q  <= s_val;
      aux_q  <= s_aux;
      end_q  <= s_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && push) nest_mem[level_d] <= push_end;
    if (cmd_i.rd) rd_q <= nest_mem[level_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      okind_q  <= kind_q;
      oval_q   <= val_q;
      oaux_q   <= aux_q;
      odepth_q <= bwtp_pkg::DepthW'(level_q);
      opops_q  <= bwtp_pkg::PopsW'(pops_q);
      oend_q   <= end_q;
    end
  end

  assign st_o.step_chk = s_emit && s_end && (s_kind < bwtp_pkg::KBadCtrl);
  assign st_o.pop_hit  = (level_q != '0) && (EntryW'(pos_q) >= rd_q);
  assign st_o.emit     = emit_q;
  assign st_o.last     = last_q;
  assign st_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign kind_o      = okind_q;
  assign value_o     = oval_q;
  assign aux_o       = oaux_q;
  assign depth_o     = odepth_q;
  assign pops_o      = opops_q;
  assign end_o       = oend_q;

endmodule

// File: src/bwtp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwtp_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwtp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [135:0] m_axis_tdata_o,
  input logic [4:0]   m_axis_tuser_o,
  input logic         m_axis_tlast_o
);

  logic err_kind, head_kind, aux_zero, no_pops;
  assign err_kind  = (m_axis_tuser_o == bwtp_pkg::KBadCtrl) ||
                     (m_axis_tuser_o == bwtp_pkg::KOverflow);
  assign head_kind = (m_axis_tuser_o == bwtp_pkg::KArrayHead);
  assign aux_zero  = (m_axis_tdata_o[127:64] == 64'd0);
  assign no_pops   = (m_axis_tdata_o[135:132] == 4'd0);

  `CHK_NEXT(a_valid_holds, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result dropped")
  `CHK_NEXT(a_word_holds, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o), "word changed")
  `CHK_ASSERT(a_kind_range, m_axis_tvalid_o |-> m_axis_tuser_o <= bwtp_pkg::KOverflow, "kind out of range")
  `CHK_ASSERT(a_aux_zero, (m_axis_tvalid_o && !head_kind) |-> aux_zero, "aux set")
  `CHK_ASSERT(a_err_no_pop, (m_axis_tvalid_o && err_kind) |-> (m_axis_tlast_o && no_pops), "error popped")

endmodule

bind binary_wire_token_parser_unit bwtp_checker u_bwtp_checker (.*);
